// File: src/tesf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesf_pkg: shared types and constants
// Register indexes, state codes and the control group that feeds the cells.
// ----------------------------------------------------------------------------
package tesf_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int KEEP_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 2'd3;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

    // control that travels along the cell row
    typedef struct packed {
        logic fill;     // write the value into the cell at the fill slot
        logic insert;   // offer the value for replacement
        logic shift;    // rotate the stored entries toward the summer
    } t_cell_ctl;

endpackage

// File: src/tesf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesf_cell: one sorted slot of a low and a high store
// Holds one low and one high entry; sorted shift-insertion with its neighbor.
// ----------------------------------------------------------------------------
module tesf_cell (
    input  logic                          i_clk,
    input  tesf_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_sel,      // this cell is in use
    input  logic                          i_fill_here,
    input  logic signed [31:0]            i_value,
    // neighbor toward the front (lower index) of the row
    input  logic                          i_prev_lo_take,
    input  logic                          i_prev_hi_take,
    input  logic signed [31:0]            i_prev_lo,
    input  logic signed [31:0]            i_prev_hi,
    input  logic                          i_first,
    // neighbor toward the back
    input  logic signed [31:0]            i_next_lo,
    input  logic signed [31:0]            i_next_hi,
    output logic                          o_lo_take,
    output logic                          o_hi_take,
    output logic signed [31:0]            o_lo,
    output logic signed [31:0]            o_hi
);
    import tesf_pkg::*;

    logic signed [31:0] r_lo, r_hi, n_lo, n_hi;

    // low store ascending, high store descending; the worst sits at the last used slot
    assign o_lo_take = i_sel && (i_value < r_lo);
    assign o_hi_take = i_sel && (i_value > r_hi);
    assign o_lo = r_lo;
    assign o_hi = r_hi;

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_ctl.shift) begin
            n_lo = i_next_lo;
            n_hi = i_next_hi;
        end else if (i_ctl.fill) begin
            if (i_fill_here) begin
                n_lo = (!i_first && !i_prev_lo_take) ? i_value : i_prev_lo;
                n_hi = (!i_first && !i_prev_hi_take) ? i_value : i_prev_hi;
                if (i_first) begin
                    n_lo = i_value;
                    n_hi = i_value;
                end else begin
                    n_lo = i_prev_lo_take ? i_prev_lo : i_value;
                    n_hi = i_prev_hi_take ? i_prev_hi : i_value;
                end
            end else if (i_sel) begin
                if (o_lo_take) begin
                    n_lo = (i_first || !i_prev_lo_take) ? i_value : i_prev_lo;
                end
                if (o_hi_take) begin
                    n_hi = (i_first || !i_prev_hi_take) ? i_value : i_prev_hi;
                end
            end
        end else if (i_ctl.insert && i_sel) begin
            // drop the worst entry, shift the tail back by one
            if (o_lo_take) begin
                n_lo = (i_first || !i_prev_lo_take) ? i_value : i_prev_lo;
            end
            if (o_hi_take) begin
                n_hi = (i_first || !i_prev_hi_take) ? i_value : i_prev_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

endmodule

// File: src/tesf_axis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tesf_axis: cell row and trimmed extent for one axis
// Keeps the sorted extremes, sums them by rotation, then divides bit-serially.
// ----------------------------------------------------------------------------
module tesf_axis #(
    parameter int KEEP_MAX = 10
) (
    input  logic                          i_clk,
    input  tesf_pkg::t_cell_ctl           i_ctl,
    input  logic [$clog2(KEEP_MAX+1)-1:0] i_count,     // entries held before this beat
    input  logic signed [31:0]            i_value,
    input  logic                          i_sum_clr,
    input  logic                          i_sum_en,
    input  logic                          i_div_start,
    input  logic                          i_div_step,
    input  logic [$clog2(KEEP_MAX+1)-1:0] i_div_n,
    input  logic [30:0]                   i_size,
    output logic [31:0]                   o_factor
);
    import tesf_pkg::*;

    localparam int CW   = $clog2(KEEP_MAX + 1);
    localparam int SW   = 32 + $clog2(KEEP_MAX + 1) + 1;  // signed sum width
    localparam int DENW = 31 + CW;
    localparam int NUMW = SW + 16;
    localparam int REMW = DENW + 1;

    logic               take_lo [KEEP_MAX];
    logic               take_hi [KEEP_MAX];
    logic signed [31:0] ent_lo  [KEEP_MAX];
    logic signed [31:0] ent_hi  [KEEP_MAX];

    genvar g;
    generate
        for (g = 0; g < KEEP_MAX; g++) begin : g_cell
            logic sel, fill_here;
            assign sel       = (CW'(g) < i_count);
            assign fill_here = (CW'(g) == i_count);
            tesf_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (i_ctl),
                .i_sel         (sel),
                .i_fill_here   (fill_here),
                .i_value       (i_value),
                .i_prev_lo_take(g == 0 ? 1'b0 : take_lo[(g == 0) ? 0 : g-1]),
                .i_prev_hi_take(g == 0 ? 1'b0 : take_hi[(g == 0) ? 0 : g-1]),
                .i_prev_lo     (ent_lo[(g == 0) ? 0 : g-1]),
                .i_prev_hi     (ent_hi[(g == 0) ? 0 : g-1]),
                .i_first       (g == 0),
                .i_next_lo     (ent_lo[(g == KEEP_MAX-1) ? 0 : g+1]),
                .i_next_hi     (ent_hi[(g == KEEP_MAX-1) ? 0 : g+1]),
                .o_lo_take     (take_lo[g]),
                .o_hi_take     (take_hi[g]),
                .o_lo          (ent_lo[g]),
                .o_hi          (ent_hi[g])
            );
        end
    endgenerate

    // sum: entries rotate past cell 0 one per cycle
    logic signed [SW-1:0] r_diff;
    always_ff @(posedge i_clk) begin
        if (i_sum_clr) begin
            r_diff <= '0;
        end else if (i_sum_en) begin
            r_diff <= r_diff + SW'(ent_hi[0]) - SW'(ent_lo[0]);
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [NUMW-1:0] r_num;
    logic [REMW-1:0] r_rem;
    logic [DENW-1:0] r_den;
    logic            r_neg;
    logic [REMW-1:0] rem_sh;
    logic            ge;

    assign rem_sh = {r_rem[REMW-2:0], r_num[NUMW-1]};
    assign ge     = rem_sh >= REMW'(r_den);

    always_ff @(posedge i_clk) begin
        if (i_div_start) begin
            r_num <= {r_diff, 16'd0};
            r_rem <= '0;
            r_den <= DENW'(i_div_n) * DENW'(i_size);
            r_neg <= (r_diff <= 0);
        end else if (i_div_step) begin
            r_rem <= ge ? rem_sh - REMW'(r_den) : rem_sh;
            r_num <= {r_num[NUMW-2:0], ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            o_factor = '0;
        end else if (r_den == '0 || |r_num[NUMW-1:32]) begin
            o_factor = 32'hFFFF_FFFF;
        end else begin
            o_factor = r_num[31:0];
        end
    end

endmodule

// File: src/trimmed_extent_scale_factor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_extent_scale_factor: trimmed per-axis extent over size
// Sorted extreme stores per axis with a serial sum and divide at set end.
// ----------------------------------------------------------------------------
// Each axis keeps its smallest and largest values in a row of sorted cells,
// one beat per cycle. A beat with last_point set ends the set: the whole row
// is rotated once to sum its entries, then a restoring divider takes a load
// step and then one quotient bit per cycle, and the result beat is held until
// taken. Input is stalled from the last point until the result beat is taken.
module trimmed_extent_scale_factor #(
    parameter int KEEP_MAX = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [31:0]              i_coord_x,
    input  logic signed [31:0]              i_coord_y,
    input  logic signed [31:0]              i_coord_z,
    input  logic                            i_last_point,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [31:0]                     o_factor_x,
    output logic [31:0]                     o_factor_y,
    output logic [31:0]                     o_factor_z,
    output logic                            o_no_points,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tesf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tesf_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import tesf_pkg::*;

    localparam int CW   = $clog2(KEEP_MAX + 1);
    localparam int NUMW = 32 + CW + 1 + 16;
    localparam int DCW  = $clog2(NUMW + KEEP_MAX + 1);

    logic [3:0]  r_keep;
    logic [30:0] r_size_x, r_size_y, r_size_z;
    t_state      r_state, n_state;
    logic [CW-1:0]  r_fill, n_fill, r_n;
    logic [DCW-1:0] r_cnt, n_cnt;
    logic           r_no_pts;

    logic [CW-1:0] keep_eff;
    logic          acc, filling;
    t_cell_ctl     ctl;
    logic          sum_clr, sum_en, div_start, div_step;

    assign keep_eff = (int'(r_keep) > KEEP_MAX) ? CW'(KEEP_MAX) : CW'(r_keep);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep   <= 4'd10;
            r_size_x <= 31'd65536;
            r_size_y <= 31'd65536;
            r_size_z <= 31'd65536;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEEP_COUNT: r_keep   <= i_cfg_data[3:0];
                REG_SIZE_X:     r_size_x <= i_cfg_data[30:0];
                REG_SIZE_Y:     r_size_y <= i_cfg_data[30:0];
                REG_SIZE_Z:     r_size_z <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_stall = (r_state != ST_RUN);
    assign acc     = i_valid && (r_state == ST_RUN);
    assign filling = r_fill < keep_eff;
    assign o_valid = (r_state == ST_OUT);

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        ctl       = '0;
        sum_clr   = 1'b0;
        sum_en    = 1'b0;
        div_start = 1'b0;
        div_step  = 1'b0;
        case (r_state)
            ST_RUN: begin
                if (acc) begin
                    ctl.fill   = filling;
                    ctl.insert = !filling;
                    if (filling) begin
                        n_fill = r_fill + 1'b1;
                    end
                    if (i_last_point) begin
                        sum_clr = 1'b1;
                        n_cnt   = '0;
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                // rotate the full row so the stores come back in order
                sum_en    = (r_cnt < DCW'(r_fill));
                ctl.shift = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == DCW'(KEEP_MAX - 1)) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    div_start = 1'b1;
                end else begin
                    div_step = 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DCW'(NUMW)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_state = ST_RUN;
                    n_fill  = '0;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_fill  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_n      <= r_fill;
            r_no_pts <= (r_fill == '0);
        end
    end

    logic [31:0] fx, fy, fz;

    tesf_axis #(.KEEP_MAX(KEEP_MAX)) u_ax_x (
        .i_clk(i_clk), .i_ctl(ctl), .i_count(r_fill), .i_value(i_coord_x),
        .i_sum_clr(sum_clr), .i_sum_en(sum_en), .i_div_start(div_start),
        .i_div_step(div_step), .i_div_n(r_fill), .i_size(r_size_x), .o_factor(fx)
    );
    tesf_axis #(.KEEP_MAX(KEEP_MAX)) u_ax_y (
        .i_clk(i_clk), .i_ctl(ctl), .i_count(r_fill), .i_value(i_coord_y),
        .i_sum_clr(sum_clr), .i_sum_en(sum_en), .i_div_start(div_start),
        .i_div_step(div_step), .i_div_n(r_fill), .i_size(r_size_y), .o_factor(fy)
    );
    tesf_axis #(.KEEP_MAX(KEEP_MAX)) u_ax_z (
        .i_clk(i_clk), .i_ctl(ctl), .i_count(r_fill), .i_value(i_coord_z),
        .i_sum_clr(sum_clr), .i_sum_en(sum_en), .i_div_start(div_start),
        .i_div_step(div_step), .i_div_n(r_fill), .i_size(r_size_z), .o_factor(fz)
    );

    assign o_no_points = r_no_pts && (r_n == '0);
    assign o_factor_x  = r_no_pts ? 32'd0 : fx;
    assign o_factor_y  = r_no_pts ? 32'd0 : fy;
    assign o_factor_z  = r_no_pts ? 32'd0 : fz;

endmodule

// File: dv/tb_trimmed_extent_scale_factor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trimmed_extent_scale_factor: self-checking bench for the extent ratio
// Streams point sets under several register settings with random idle and
// stall bursts, predicts each set's per-axis ratios and compares every beat.
// ----------------------------------------------------------------------------
module tb_trimmed_extent_scale_factor;
    import tesf_pkg::*;

    localparam int KEEP_LIMIT = 10;
    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic [2:0][31:0] coord;
        logic             last;
    } point_t;

    typedef struct {
        logic [2:0][31:0] factor;
        logic             none;
    } ratio_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic signed [31:0] i_coord_z = '0;
    logic i_last_point = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [31:0] o_factor_x, o_factor_y, o_factor_z;
    logic o_no_points;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    trimmed_extent_scale_factor dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [3:0]         keep_reg = 4'd10;
    logic [2:0][30:0]   size_reg = {3{31'd65536}};
    logic signed [31:0] lowest [3][KEEP_LIMIT];
    logic signed [31:0] highest [3][KEEP_LIMIT];
    int unsigned        held = 0;

    point_t pending_points[$];
    ratio_t expected_ratios[$];
    int     fail_count = 0;
    int     idle_pct = 25;
    bit     quiet = 1'b0;

    function automatic logic [31:0] axis_ratio(int ax, int unsigned n, logic [30:0] sz);
        longint sum_lo, sum_hi, diff;
        longint unsigned num, den, q;
        sum_lo = 0;
        sum_hi = 0;
        for (int i = 0; i < n; i++) begin
            sum_lo += lowest[ax][i];
            sum_hi += highest[ax][i];
        end
        diff = sum_hi - sum_lo;
        if (diff <= 0) return 32'd0;
        if (sz == 0) return 32'hFFFF_FFFF;
        num = longint'(diff) * 65536;
        den = longint'(n) * longint'(sz);
        q = num / den;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    task automatic predict_point(point_t p);
        int unsigned k, n, worst;
        bit filling;
        logic signed [31:0] v;
        ratio_t r;
        k = (keep_reg > KEEP_LIMIT) ? KEEP_LIMIT : keep_reg;
        n = held;
        filling = n < k;
        for (int a = 0; a < 3; a++) begin
            v = p.coord[a];
            if (filling) begin
                lowest[a][n] = v;
                highest[a][n] = v;
            end else if (n != 0) begin
                worst = 0;
                for (int i = 1; i < n; i++)
                    if (lowest[a][i] > lowest[a][worst]) worst = i;
                if (v < lowest[a][worst]) lowest[a][worst] = v;
                worst = 0;
                for (int i = 1; i < n; i++)
                    if (highest[a][i] < highest[a][worst]) worst = i;
                if (v > highest[a][worst]) highest[a][worst] = v;
            end
        end
        if (filling) held = n + 1;
        if (p.last) begin
            r.none = (held == 0);
            for (int a = 0; a < 3; a++)
                r.factor[a] = r.none ? 32'd0 : axis_ratio(a, held, size_reg[a]);
            expected_ratios.push_back(r);
            held = 0;
        end
    endtask

    // point driver
    point_t cur_point;
    int     send_gap = 0;
    int     accept_idle = 0;

    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            predict_point(cur_point);
        end
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && o_stall) begin
            i_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            i_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
            cur_point = pending_points.pop_front();
            i_coord_x <= cur_point.coord[0];
            i_coord_y <= cur_point.coord[1];
            i_coord_z <= cur_point.coord[2];
            i_last_point <= cur_point.last;
            i_valid <= 1'b1;
            if (!quiet && $urandom_range(99) < idle_pct) send_gap <= $urandom_range(1, 14);
        end else begin
            i_valid <= 1'b0;
        end
    end

    // result stall bursts
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(99) < idle_pct) begin
            stall_left <= $urandom_range(0, 13);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        ratio_t want;
        if (o_valid && !i_stall) begin
            if (expected_ratios.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat x=%h y=%h z=%h none=%b",
                             o_factor_x, o_factor_y, o_factor_z, o_no_points);
            end else begin
                want = expected_ratios.pop_front();
                if (o_factor_x !== want.factor[0] || o_factor_y !== want.factor[1] ||
                    o_factor_z !== want.factor[2] || o_no_points !== want.none) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ratio beat: expected %h %h %h %b, got %h %h %h %b",
                                 want.factor[0], want.factor[1], want.factor[2], want.none,
                                 o_factor_x, o_factor_y, o_factor_z, o_no_points);
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            accept_idle <= 0;
        else if (accept_idle >= STALL_LIMIT) begin
            $display("trimmed_extent_scale_factor: mismatch");
            $finish;
        end else
            accept_idle <= accept_idle + 1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_KEEP_COUNT: keep_reg = data[3:0];
            REG_SIZE_X:     size_reg[0] = data[30:0];
            REG_SIZE_Y:     size_reg[1] = data[30:0];
            REG_SIZE_Z:     size_reg[2] = data[30:0];
            default: ;
        endcase
    endtask

    // wait until the point stream has drained and the block has gone quiet
    task automatic settle();
        wait (pending_points.size() == 0 && expected_ratios.size() == 0);
        @(posedge i_clk);
        while (i_valid || pending_points.size() != 0 || expected_ratios.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                      logic last);
        point_t p;
        p.coord = {z, y, x};
        p.last = last;
        pending_points.push_back(p);
    endfunction

    function automatic logic [31:0] rand_coord(logic [31:0] prev);
        case ($urandom_range(0, 6))
            0, 1: return $urandom;
            2:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            3:    return 32'h8000_0000;
            4:    return 32'h7FFF_FFFF;
            5:    return prev;
            default: return prev + $urandom_range(0, 255) - 128;
        endcase
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 4))
            0: return 32'd1;
            1: return 32'h7FFF_FFFF;
            2: return 32'd65536;
            3: return $urandom_range(1, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_sets(int count);
        logic [2:0][31:0] prev;
        int len, pos;
        prev = '0;
        len = 0;
        pos = 0;
        for (int i = 0; i < count; i++) begin
            if (pos == len) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 14);
                pos = 0;
            end
            for (int a = 0; a < 3; a++) prev[a] = rand_coord(prev[a]);
            pos++;
            add_point(prev[0], prev[1], prev[2], (pos == len) || (i == count - 1));
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes at reset settings
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_point(32'h0001_0000, 32'hFFFF_0000, 32'h4000_0000, 1'b1);
        add_point(32'h1234_5678, 32'h0, 32'h0, 1'b1);
        for (int i = 0; i < 12; i++)
            add_point(i * 32'h0001_1000 - 32'h0004_0000, -i * 32'h300, 32'h55AA_0000 ^ i,
                      i == 11);
        settle();

        // empty store gives the flag
        write_reg(REG_KEEP_COUNT, 32'd0);
        add_point(32'h0003_0000, 32'h0, 32'h0, 1'b0);
        add_point(32'h0005_0000, 32'h1, 32'h2, 1'b1);
        settle();

        // keep count lowered while the stores are still filling
        write_reg(REG_KEEP_COUNT, 32'd10);
        for (int i = 0; i < 5; i++) add_point(i << 16, -(i << 16), i << 20, 1'b0);
        settle();
        write_reg(REG_KEEP_COUNT, 32'd3);
        write_reg(REG_SIZE_X, 32'hFFFF_FFFF);
        write_reg(REG_SIZE_Y, 32'd1);
        write_reg(REG_SIZE_Z, 32'h8000_0000);
        add_point(32'h7FFF_0000, 32'h8000_0000, 32'h1, 1'b0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h2, 1'b1);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_reg(REG_KEEP_COUNT, 32'd1);
                1: write_reg(REG_KEEP_COUNT, 32'd15);
                2: write_reg(REG_KEEP_COUNT, 32'd10);
                default: write_reg(REG_KEEP_COUNT, {$urandom} & 32'hFFFF_FFF0 |
                                                   $urandom_range(0, 15));
            endcase
            write_reg(REG_SIZE_X, rand_size());
            write_reg(REG_SIZE_Y, rand_size());
            write_reg(REG_SIZE_Z, rand_size());
            idle_pct = (ph == 3) ? 0 : $urandom_range(10, 40);
            quiet = (ph == 7);
            random_sets(110);
            settle();
        end

        if (fail_count == 0)
            $display("trimmed_extent_scale_factor: match");
        else
            $display("trimmed_extent_scale_factor: mismatch");
        $finish;
    end

endmodule
